FILE: sv/ced_pkg.sv
// shared types for the c escape string decoder
// one queue entry holds every result caused by one input character
// no dependencies
package ced_pkg;

  typedef struct packed {
    logic        done;
    logic [7:0]  data;
    logic [15:0] len;
  } res_t;

  // slot 0 only ever carries a flushed pending escape byte
  // slot 1 carries a byte or the closing done result
  typedef struct packed {
    logic has0;
    res_t r0;
    logic has1;
    res_t r1;
  } entry_t;

endpackage

FILE: sv/ced_front.sv
// front end: accepts characters, runs the escape state machine and the byte budget
// depends on ced_pkg for the queue entry type
module ced_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic               q_full,
  output logic               push,
  output ced_pkg::entry_t    push_entry
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] B_LF     = 8'h0A;
  localparam logic [7:0] B_CR     = 8'h0D;
  localparam logic [7:0] B_TAB    = 8'h09;
  localparam logic [7:0] B_ESC    = 8'h1B;
  localparam logic [15:0] MAX_LEN_RST = 16'd256;

  typedef enum logic [2:0] {
    M_TEXT = 3'd0,
    M_ESC  = 3'd1,
    M_HEX0 = 3'd2,
    M_HEX1 = 3'd3,
    M_OCT1 = 3'd4,
    M_OCT2 = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [5:0]  pend, pend_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] max_len;

  logic        accept;
  logic        is_end;
  logic        is_hex, is_oct;
  logic [3:0]  hval;
  logic        plain_want;
  mode_t       plain_mode;
  logic        flush_want, sec_want;
  logic [7:0]  sec_byte;
  logic        ok0, ok1;
  logic [15:0] count1, count2;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_end   = (ch == CH_NUL);
  assign is_oct   = (ch >= CH_0) && (ch <= CH_7);

  always_comb begin
    is_hex = 1'b1;
    hval   = 4'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      hval = 4'(ch - CH_0);
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      hval = 4'(ch - CH_LA + 8'd10);
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      hval = 4'(ch - CH_UA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // plain text handling: backslash opens an escape, anything else is copied
  assign plain_want = (ch != CH_BSL);
  assign plain_mode = (ch == CH_BSL) ? M_ESC : M_TEXT;

  always_comb begin
    flush_want = 1'b0;
    sec_want   = 1'b0;
    sec_byte   = ch;
    mode_next  = mode;
    pend_next  = pend;
    if (is_end) begin
      flush_want = (mode == M_HEX1) || (mode == M_OCT1) || (mode == M_OCT2);
      mode_next  = M_TEXT;
    end else begin
      unique case (mode)
        M_ESC: begin
          mode_next = M_TEXT;
          if (ch == CH_BSL || ch == CH_QUOTE) begin
            sec_want = 1'b1;
          end else if (ch == CH_N) begin
            sec_want = 1'b1;
            sec_byte = B_LF;
          end else if (ch == CH_R) begin
            sec_want = 1'b1;
            sec_byte = B_CR;
          end else if (ch == CH_T) begin
            sec_want = 1'b1;
            sec_byte = B_TAB;
          end else if (ch == CH_E) begin
            sec_want = 1'b1;
            sec_byte = B_ESC;
          end else if (ch == CH_X) begin
            mode_next = M_HEX0;
          end else if (is_oct) begin
            mode_next = M_OCT1;
            pend_next = {3'd0, ch[2:0]};
          end else begin
            sec_want  = plain_want;
            mode_next = plain_mode;
          end
        end
        M_HEX0: begin
          if (is_hex) begin
            mode_next = M_HEX1;
            pend_next = {2'd0, hval};
          end else begin
            sec_want  = plain_want;
            mode_next = plain_mode;
          end
        end
        M_HEX1: begin
          if (is_hex) begin
            sec_want  = 1'b1;
            sec_byte  = {pend[3:0], hval};
            mode_next = M_TEXT;
          end else begin
            flush_want = 1'b1;
            sec_want   = plain_want;
            mode_next  = plain_mode;
          end
        end
        M_OCT1: begin
          if (is_oct) begin
            mode_next = M_OCT2;
            pend_next = {pend[2:0], ch[2:0]};
          end else begin
            flush_want = 1'b1;
            sec_want   = plain_want;
            mode_next  = plain_mode;
          end
        end
        M_OCT2: begin
          if (is_oct) begin
            sec_want  = 1'b1;
            sec_byte  = {pend[4:0], ch[2:0]};
            mode_next = M_TEXT;
          end else begin
            flush_want = 1'b1;
            sec_want   = plain_want;
            mode_next  = plain_mode;
          end
        end
        default: begin
          sec_want  = plain_want;
          mode_next = plain_mode;
        end
      endcase
    end
    // digits are only held while an escape still waits for more
    if (!(mode_next == M_HEX1 || mode_next == M_OCT1 || mode_next == M_OCT2)) begin
      pend_next = 6'd0;
    end
  end

  // byte budget: a byte is kept only while count + 1 < max_len
  always_comb begin
    ok0    = flush_want && (({1'b0, byte_count} + 17'd1) < {1'b0, max_len});
    count1 = byte_count + {15'd0, ok0};
    ok1    = sec_want && !is_end && (({1'b0, count1} + 17'd1) < {1'b0, max_len});
    count2 = count1 + {15'd0, ok1};
    byte_count_next = is_end ? 16'd0 : count2;
  end

  always_comb begin
    push_entry.has0    = ok0;
    push_entry.r0.done = 1'b0;
    push_entry.r0.data = {2'd0, pend};
    push_entry.r0.len  = count1;
    push_entry.has1    = ok1 || is_end;
    push_entry.r1.done = is_end;
    push_entry.r1.data = is_end ? 8'd0 : sec_byte;
    push_entry.r1.len  = is_end ? count1 : count2;
    push = accept && (ok0 || ok1 || is_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_TEXT;
      pend       <= 6'd0;
      byte_count <= 16'd0;
      max_len    <= MAX_LEN_RST;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (accept) begin
        mode       <= mode_next;
        pend       <= pend_next;
        byte_count <= byte_count_next;
      end
    end
  end

endmodule

FILE: sv/ced_queue.sv
// short fifo of result entries between the front end and the output side
// depends on ced_pkg for the entry type
module ced_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ced_pkg::entry_t wr_entry,
  input  logic            pop,
  output ced_pkg::entry_t head,
  output logic            empty,
  output logic            full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ced_pkg::entry_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  cnt;

  assign empty = (cnt == CNT_W'(0));
  assign full  = (cnt == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/ced_back.sv
// output side: walks the one or two results of the head entry, one per transfer
// depends on ced_pkg for the entry type
module ced_back (
  input  logic            clk,
  input  logic            rst,
  input  ced_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            done_res,
  output logic [15:0]     length,
  output logic            last
);

  logic          phase;
  logic          sel0;
  ced_pkg::res_t cur;

  assign out_valid  = !empty;
  assign sel0       = !phase && head.has0;
  assign cur        = sel0 ? head.r0 : head.r1;
  assign last       = !(sel0 && head.has1);
  assign out_byte   = cur.data;
  assign byte_valid = !cur.done;
  assign done_res   = cur.done;
  assign length     = cur.len;
  assign pop        = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (out_valid && out_ready) begin
      phase <= !last;
    end
  end

endmodule

FILE: sv/c_escape_string_decoder_core.sv
// c escape string decoder, top level
// depends on ced_pkg, ced_front, ced_queue and ced_back
//
// One character is taken per cycle while the result queue has room; a 0 ends the
// string. Each character gives zero, one or two results (a flushed pending escape
// byte, then a byte or the closing done result), and the output side sends one
// result per cycle while out_ready is high, so a character with two results costs
// two transfers. The escape state and the byte budget are updated in the same
// cycle the character is taken. max_len may be rewritten only while the block is
// idle; at most max_len-1 bytes per string are sent and later bytes are dropped.
module c_escape_string_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        done_res,
  output logic [15:0] length,
  output logic        last
);

  ced_pkg::entry_t push_entry, head;
  logic            push, pop, q_empty, q_full;

  ced_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ced_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .done_res   (done_res),
    .length     (length),
    .last       (last)
  );

  // the closing result carries no byte
  a_done_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !byte_valid && out_byte == 8'd0)
    else $error("done result carries a byte");

  // a sent byte always counts itself
  a_byte_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> length != 16'd0)
    else $error("byte result with zero length");

  // the second result of a character follows right after the first transfer
  a_second_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("second result of a character missing");

  // input backpressure only comes from a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing to send");

endmodule

FILE: verif/ced_scoreboard_pkg.sv
// scoreboard for the c escape string decoder testbench
// holds a decoder model that predicts each result and checks what the block sends
// no dependencies
package ced_scoreboard_pkg;

  typedef enum logic [2:0] {
    ST_TEXT,
    ST_ESC,
    ST_HEX0,
    ST_HEX1,
    ST_OCT1,
    ST_OCT2
  } esc_state_e;

  typedef struct {
    logic [7:0]  data;
    logic        valid;
    logic        done;
    logic [15:0] len;
    logic        last;
  } decoded_t;

  class escape_scoreboard;
    logic [15:0] max_len;
    esc_state_e  state;
    logic [8:0]  digits;
    logic [15:0] count;
    decoded_t    expected_q[$];
    decoded_t    step_q[$];
    int          errors;

    function new();
      max_len = 16'd256;
      state   = ST_TEXT;
      digits  = '0;
      count   = '0;
      errors  = 0;
    endfunction

    function void set_max_len(logic [15:0] v);
      max_len = v;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function bit is_octal(logic [7:0] c);
      return c >= "0" && c <= "7";
    endfunction

    function void push_result(logic [7:0] b, logic v, logic d);
      decoded_t r;
      r.data  = b;
      r.valid = v;
      r.done  = d;
      r.len   = count;
      r.last  = 1'b0;
      step_q.push_back(r);
    endfunction

    // bytes past max_len-1 are dropped silently
    function void put_byte(logic [7:0] b);
      if ({1'b0, count} + 17'd1 < {1'b0, max_len}) begin
        count = count + 16'd1;
        push_result(b, 1'b1, 1'b0);
      end
    endfunction

    function void plain_char(logic [7:0] c);
      state = ST_TEXT;
      if (c == "\\") state = ST_ESC;
      else put_byte(c);
    endfunction

    // called for every character transfer accepted by the block
    function void note_char(logic [7:0] c);
      int h;
      logic [3:0] nib;
      h = hex_value(c);
      nib = h[3:0];
      step_q.delete();
      if (c == 8'h00) begin
        if (state inside {ST_HEX1, ST_OCT1, ST_OCT2}) put_byte(digits[7:0]);
        push_result(8'h00, 1'b0, 1'b1);
        state  = ST_TEXT;
        digits = '0;
        count  = '0;
      end else begin
        case (state)
          ST_ESC: begin
            state = ST_TEXT;
            if (c == "\\" || c == "\"") put_byte(c);
            else if (c == "n") put_byte(8'h0a);
            else if (c == "r") put_byte(8'h0d);
            else if (c == "t") put_byte(8'h09);
            else if (c == "e") put_byte(8'h1b);
            else if (c == "x") begin
              state  = ST_HEX0;
              digits = '0;
            end else if (is_octal(c)) begin
              state  = ST_OCT1;
              digits = {6'd0, c[2:0]};
            end else plain_char(c);
          end
          ST_HEX0: begin
            if (h >= 0) begin
              state  = ST_HEX1;
              digits = {5'd0, nib};
            end else plain_char(c);
          end
          ST_HEX1: begin
            if (h >= 0) begin
              state = ST_TEXT;
              put_byte({digits[3:0], nib});
            end else begin
              put_byte(digits[7:0]);
              plain_char(c);
            end
          end
          ST_OCT1: begin
            if (is_octal(c)) begin
              state  = ST_OCT2;
              digits = {3'd0, digits[2:0], c[2:0]};
            end else begin
              put_byte(digits[7:0]);
              plain_char(c);
            end
          end
          ST_OCT2: begin
            if (is_octal(c)) begin
              state = ST_TEXT;
              put_byte({digits[4:0], c[2:0]});
            end else begin
              put_byte(digits[7:0]);
              plain_char(c);
            end
          end
          default: plain_char(c);
        endcase
        if (state inside {ST_TEXT, ST_ESC, ST_HEX0}) digits = '0;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void check_result(logic [7:0] b, logic v, logic d, logic [15:0] len, logic lst);
      decoded_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result byte %h valid %b done %b len %0d last %b",
                   $realtime, b, v, d, len, lst);
        return;
      end
      e = expected_q.pop_front();
      if (b !== e.data || v !== e.valid || d !== e.done || len !== e.len || lst !== e.last)
      begin
        errors++;
        if (errors <= 10)
          $display("%0t: bad result, expected byte %h valid %b done %b len %0d last %b, %s",
                   $realtime, e.data, e.valid, e.done, e.len, e.last,
                   $sformatf("got byte %h valid %b done %b len %0d last %b",
                             b, v, d, len, lst));
      end
    endfunction
  endclass

endpackage

FILE: verif/tb_top.sv
// testbench top for c_escape_string_decoder_core
// depends on ced_scoreboard_pkg and the decoder rtl
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_CHARS = 150;
  localparam int NUM_PHASES  = 9;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        done_res;
  logic [15:0] length;
  logic        last;

  ced_scoreboard_pkg::escape_scoreboard sb;
  int tx_idle_pct = 35;
  int rx_idle_pct = 57;
  bit hold_req = 1'b0;
  int chars_sent = 0;
  int stall_cycles = 0;

  c_escape_string_decoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .done_res   (done_res),
    .length     (length),
    .last       (last)
  );

  always #5 clk = ~clk;

  // input transfers are noted before output transfers of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_char(ch);
      if (out_valid && out_ready)
        sb.check_result(out_byte, byte_valid, done_res, length, last);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_max_len(v);
  endtask

  // drop valid, wait for every expected result, then let a dropped byte settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == "\\") c = "a";
    return c;
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 5))
      0: return "\\";
      1: return "\"";
      2: return "n";
      3: return "r";
      4: return "t";
      default: return "e";
    endcase
  endfunction

  function automatic logic [7:0] hex_digit();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(int'("0") + v);
    if (v < 16) return 8'(int'("a") + v - 10);
    return 8'(int'("A") + v - 16);
  endfunction

  function automatic logic [7:0] octal_digit();
    return 8'(int'("0") + $urandom_range(0, 7));
  endfunction

  task automatic send_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_char(plain_byte());
    end else if (pick < 50) begin
      send_char("\\");
      send_char(simple_escape());
    end else if (pick < 65) begin
      send_char("\\");
      send_char("x");
      repeat ($urandom_range(0, 2)) send_char(hex_digit());
    end else if (pick < 80) begin
      send_char("\\");
      repeat ($urandom_range(1, 3)) send_char(octal_digit());
    end else if (pick < 88) begin
      send_char("\\");
      send_char(8'($urandom_range(1, 255)));
    end else begin
      send_char(8'($urandom_range(1, 255)));
    end
  endtask

  // mostly short strings, now and then a long one; a few run on unterminated
  task automatic send_string();
    int ntok;
    ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    repeat (ntok) send_token();
    if ($urandom_range(0, 19) != 0) send_char(8'h00);
  endtask

  initial begin
    logic [15:0] phase_len [NUM_PHASES];
    int target;
    sb = new();
    phase_len = '{16'd0, 16'd3, 16'd65535, 16'd1, 16'd17, 16'd2, 16'd256, 16'd9,
                  16'd65535};
    phase_len[7] = 16'($urandom_range(4, 40));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // escapes, flushes, bare \x, pending digits and trailing backslash at the terminator
    send_text("\\n\\x4g\\777\\8\\1\\e");
    send_char(8'hff);
    send_text("\\x");
    send_char(8'h00);
    send_text("\\\"\\\\\\7");
    send_char(8'h00);
    send_text("\\");
    send_char(8'h00);
    wait_drained();

    target = chars_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle_pct = (p < 3) ? 35 : (p < 6) ? 57 : 0;
      rx_idle_pct = (p < 3) ? 57 : (p < 6) ? 35 : 0;
      write_max_len(phase_len[p]);
      if (p == 4) hold_req = 1'b1;
      target += PHASE_CHARS;
      while (chars_sent < target) send_string();
      wait_drained();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: c_escape_string_decoder_core.f
sv/ced_pkg.sv
sv/ced_front.sv
sv/ced_queue.sv
sv/ced_back.sv
sv/c_escape_string_decoder_core.sv
verif/ced_scoreboard_pkg.sv
verif/tb_top.sv
